FILE: design/c25519fs_pkg.sv
// Shared widths, operand tables and control types for the field squaring block.
package c25519fs_pkg;

   // Limb and word widths.
   localparam int unsigned NUM_LIMBS  = 5;
   localparam int unsigned TERMS      = 3;
   localparam int unsigned IN_W       = 52;
   localparam int unsigned LIMB_W     = 51;
   localparam int unsigned OUT1_W     = 52;
   localparam int unsigned SCALED_W   = 58;
   localparam int unsigned X_SPLIT    = 29;
   localparam int unsigned Y_SPLIT    = 26;
   localparam int unsigned PP_W       = 55;
   localparam int unsigned PROD_W     = 110;
   localparam int unsigned COL_W      = 112;
   localparam int unsigned SUM_W      = COL_W + 1;
   localparam int unsigned CY_W       = SUM_W - LIMB_W;
   localparam int unsigned FOLD_W     = 64;
   localparam int unsigned TOP_CY_W   = FOLD_W - LIMB_W;

   // Pipeline depths: lane stages first, then the carry chain, fold and output.
   localparam int unsigned LANE_STAGES  = 4;
   localparam int unsigned MERGE_STAGES = NUM_LIMBS + 2;
   localparam int unsigned FOLD_STAGE   = NUM_LIMBS;
   localparam int unsigned OUT_STAGE    = NUM_LIMBS + 1;
   localparam int unsigned TOTAL_STAGES = LANE_STAGES + MERGE_STAGES;

   // Constant factor applied to a product term.
   typedef logic [1:0] scale_type;
   localparam scale_type SCALE_1  = 2'd0;
   localparam scale_type SCALE_2  = 2'd1;
   localparam scale_type SCALE_19 = 2'd2;
   localparam scale_type SCALE_38 = 2'd3;

   typedef logic [2:0] limb_idx_type;

   // Column i is the sum over t of SCALE[i][t] * a[X_SEL[i][t]] * a[Y_SEL[i][t]].
   localparam limb_idx_type X_SEL [NUM_LIMBS][TERMS] = '{
      '{3'd0, 3'd1, 3'd2},
      '{3'd0, 3'd3, 3'd2},
      '{3'd0, 3'd1, 3'd3},
      '{3'd0, 3'd1, 3'd4},
      '{3'd0, 3'd1, 3'd2}
   };
   localparam limb_idx_type Y_SEL [NUM_LIMBS][TERMS] = '{
      '{3'd0, 3'd4, 3'd3},
      '{3'd1, 3'd3, 3'd4},
      '{3'd2, 3'd1, 3'd4},
      '{3'd3, 3'd2, 3'd4},
      '{3'd4, 3'd3, 3'd2}
   };
   localparam scale_type SCALE_SEL [NUM_LIMBS][TERMS] = '{
      '{SCALE_1, SCALE_38, SCALE_38},
      '{SCALE_2, SCALE_19, SCALE_38},
      '{SCALE_2, SCALE_1,  SCALE_38},
      '{SCALE_2, SCALE_2,  SCALE_19},
      '{SCALE_2, SCALE_2,  SCALE_1}
   };

   // Stage load enables handed down from the pipeline control.
   typedef struct packed {
      logic [LANE_STAGES-1:0] en;
   } lane_ctl_type;

   typedef struct packed {
      logic [MERGE_STAGES-1:0] en;
   } merge_ctl_type;

endpackage

FILE: design/c25519fs_lane.sv
// One column lane: scales operands, multiplies in partial products and sums three terms.
module c25519fs_lane (
   input  logic                                   clock,
   input  c25519fs_pkg::lane_ctl_type             ctl,
   input  logic [c25519fs_pkg::IN_W-1:0]          x     [c25519fs_pkg::TERMS],
   input  logic [c25519fs_pkg::IN_W-1:0]          y     [c25519fs_pkg::TERMS],
   input  c25519fs_pkg::scale_type                scale [c25519fs_pkg::TERMS],
   output logic [c25519fs_pkg::COL_W-1:0]         col
);

   localparam int unsigned TERMS    = c25519fs_pkg::TERMS;
   localparam int unsigned SCALED_W = c25519fs_pkg::SCALED_W;
   localparam int unsigned IN_W     = c25519fs_pkg::IN_W;
   localparam int unsigned PP_W     = c25519fs_pkg::PP_W;
   localparam int unsigned PROD_W   = c25519fs_pkg::PROD_W;
   localparam int unsigned COL_W    = c25519fs_pkg::COL_W;
   localparam int unsigned XS       = c25519fs_pkg::X_SPLIT;
   localparam int unsigned YS       = c25519fs_pkg::Y_SPLIT;

   logic [SCALED_W-1:0] xs_in  [TERMS];
   logic [SCALED_W-1:0] xs_ff  [TERMS];
   logic [IN_W-1:0]     y_ff   [TERMS];
   logic [PP_W-1:0]     ll_in  [TERMS];
   logic [PP_W-1:0]     lh_in  [TERMS];
   logic [PP_W-1:0]     hl_in  [TERMS];
   logic [PP_W-1:0]     hh_in  [TERMS];
   logic [PP_W-1:0]     ll_ff  [TERMS];
   logic [PP_W-1:0]     lh_ff  [TERMS];
   logic [PP_W-1:0]     hl_ff  [TERMS];
   logic [PP_W-1:0]     hh_ff  [TERMS];
   logic [PROD_W-1:0]   prod_in [TERMS];
   logic [PROD_W-1:0]   prod_ff [TERMS];
   logic [COL_W-1:0]    col_in;
   logic [COL_W-1:0]    col_ff;

   // Scale each left operand by its constant factor with shifts and adds.
   always_comb begin
      for (int t = 0; t < TERMS; t++) begin
         logic [SCALED_W-1:0] xe;
         xe = SCALED_W'(x[t]);
         unique case (scale[t])
            c25519fs_pkg::SCALE_1:  xs_in[t] = xe;
            c25519fs_pkg::SCALE_2:  xs_in[t] = xe << 1;
            c25519fs_pkg::SCALE_19: xs_in[t] = (xe << 4) + (xe << 1) + xe;
            c25519fs_pkg::SCALE_38: xs_in[t] = (xe << 5) + (xe << 2) + (xe << 1);
            default:                xs_in[t] = xe;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         xs_ff <= xs_in;
         y_ff  <= y;
      end
   end

   // Four partial products per term, each at most 29 by 26 bits.
   always_comb begin
      for (int t = 0; t < TERMS; t++) begin
         ll_in[t] = PP_W'(xs_ff[t][XS-1:0])        * PP_W'(y_ff[t][YS-1:0]);
         lh_in[t] = PP_W'(xs_ff[t][XS-1:0])        * PP_W'(y_ff[t][IN_W-1:YS]);
         hl_in[t] = PP_W'(xs_ff[t][SCALED_W-1:XS]) * PP_W'(y_ff[t][YS-1:0]);
         hh_in[t] = PP_W'(xs_ff[t][SCALED_W-1:XS]) * PP_W'(y_ff[t][IN_W-1:YS]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
   end

   // Assemble each full product from its aligned partial products.
   always_comb begin
      for (int t = 0; t < TERMS; t++) begin
         prod_in[t] = PROD_W'(ll_ff[t])
                    + (PROD_W'(lh_ff[t]) << YS)
                    + (PROD_W'(hl_ff[t]) << XS)
                    + (PROD_W'(hh_ff[t]) << (XS + YS));
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         prod_ff <= prod_in;
      end
   end

   // Column sum of the three terms.
   assign col_in = COL_W'(prod_ff[0]) + COL_W'(prod_ff[1]) + COL_W'(prod_ff[2]);

   always_ff @(posedge clock) begin
      if (ctl.en[3]) begin
         col_ff <= col_in;
      end
   end

   assign col = col_ff;

endmodule

FILE: design/c25519fs_merge.sv
// Merging stage: pipelined carry chain over the columns, fold of the top carry and output.
module c25519fs_merge (
   input  logic                                clock,
   input  c25519fs_pkg::merge_ctl_type         ctl,
   input  logic [c25519fs_pkg::COL_W-1:0]      col [c25519fs_pkg::NUM_LIMBS],
   output logic [c25519fs_pkg::LIMB_W-1:0]     out_limb_0,
   output logic [c25519fs_pkg::OUT1_W-1:0]     out_limb_1,
   output logic [c25519fs_pkg::LIMB_W-1:0]     out_limb_2,
   output logic [c25519fs_pkg::LIMB_W-1:0]     out_limb_3,
   output logic [c25519fs_pkg::LIMB_W-1:0]     out_limb_4
);

   localparam int unsigned NL       = c25519fs_pkg::NUM_LIMBS;
   localparam int unsigned COL_W    = c25519fs_pkg::COL_W;
   localparam int unsigned SUM_W    = c25519fs_pkg::SUM_W;
   localparam int unsigned LIMB_W   = c25519fs_pkg::LIMB_W;
   localparam int unsigned CY_W     = c25519fs_pkg::CY_W;
   localparam int unsigned FOLD_W   = c25519fs_pkg::FOLD_W;
   localparam int unsigned OUT1_W   = c25519fs_pkg::OUT1_W;
   localparam int unsigned TOP_CY_W = c25519fs_pkg::TOP_CY_W;

   logic [COL_W-1:0]  col_ff  [NL][NL];
   logic [LIMB_W-1:0] limb_ff [NL][NL];
   logic [CY_W-1:0]   cy_ff   [NL];

   // One carry step per stage: add the incoming carry to column j and split it.
   for (genvar j = 0; j < NL; j++) begin : g_carry
      logic [COL_W-1:0]  col_src  [NL];
      logic [LIMB_W-1:0] limb_src [NL];
      logic [CY_W-1:0]   cy_src;
      logic [SUM_W-1:0]  sum;

      if (j == 0) begin : g_first
         always_comb begin
            for (int k = 0; k < NL; k++) begin
               col_src[k]  = col[k];
               limb_src[k] = '0;
            end
            cy_src = '0;
         end
      end else begin : g_next
         always_comb begin
            for (int k = 0; k < NL; k++) begin
               col_src[k]  = col_ff[j-1][k];
               limb_src[k] = limb_ff[j-1][k];
            end
            cy_src = cy_ff[j-1];
         end
      end

      assign sum = SUM_W'(col_src[j]) + SUM_W'(cy_src);

      always_ff @(posedge clock) begin
         if (ctl.en[j]) begin
            for (int k = 0; k < NL; k++) begin
               col_ff[j][k]  <= col_src[k];
               limb_ff[j][k] <= (k == j) ? sum[LIMB_W-1:0] : limb_src[k];
            end
            cy_ff[j] <= sum[SUM_W-1:LIMB_W];
         end
      end
   end

   // Fold the carry out of the top column back into limb 0, times 19.
   logic [FOLD_W-1:0] cy_ext;
   logic [FOLD_W-1:0] fold_in;
   logic [FOLD_W-1:0] fold_ff;
   logic [LIMB_W-1:0] hold_ff [1:NL-1];

   assign cy_ext  = FOLD_W'(cy_ff[NL-1]);
   assign fold_in = FOLD_W'(limb_ff[NL-1][0]) + (cy_ext << 4) + (cy_ext << 1) + cy_ext;

   always_ff @(posedge clock) begin
      if (ctl.en[c25519fs_pkg::FOLD_STAGE]) begin
         fold_ff <= fold_in;
         for (int k = 1; k < NL; k++) begin
            hold_ff[k] <= limb_ff[NL-1][k];
         end
      end
   end

   // Output register: mask limb 0 and pass its small carry into limb 1.
   logic [LIMB_W-1:0] out0_ff;
   logic [OUT1_W-1:0] out1_ff;
   logic [LIMB_W-1:0] out2_ff;
   logic [LIMB_W-1:0] out3_ff;
   logic [LIMB_W-1:0] out4_ff;
   logic [TOP_CY_W-1:0] top_cy;

   assign top_cy = fold_ff[FOLD_W-1:LIMB_W];

   always_ff @(posedge clock) begin
      if (ctl.en[c25519fs_pkg::OUT_STAGE]) begin
         out0_ff <= fold_ff[LIMB_W-1:0];
         out1_ff <= OUT1_W'(hold_ff[1]) + OUT1_W'(top_cy);
         out2_ff <= hold_ff[2];
         out3_ff <= hold_ff[3];
         out4_ff <= hold_ff[4];
      end
   end

   assign out_limb_0 = out0_ff;
   assign out_limb_1 = out1_ff;
   assign out_limb_2 = out2_ff;
   assign out_limb_3 = out3_ff;
   assign out_limb_4 = out4_ff;

endmodule

FILE: design/curve25519_field_square.sv
// Top level of the GF(2^255-19) squaring block: five column lanes, merge stage and flow control.
//
// Usage: an operand word of five 52-bit limbs enters on the req_ channel and
// its partly reduced square leaves on the rsp_ channel; both use valid/ready.
// Each of the five lanes forms one 112-bit column sum in four stages (operand
// scaling, 29x26-bit partial products, product assembly, column add). The
// merge stage then runs the carry chain one column per stage, folds the top
// carry times 19 into limb 0 and registers the result, seven stages in all.
// Throughput is one word per cycle while the pipeline is not stalled; the
// depth of the lanes and of the merge stage sets the latency, and no stage
// holds both a multiplier and a wide add. Every stage has its own valid bit
// and loads whenever it is empty or the stage after it can move, so empty
// slots close up: while a result waits on rsp_ready, new words are still
// taken until every stage is full, and only then does req_ready fall.
// Nothing in flight is lost or duplicated during a stall.
// Reset (synchronous, active high) clears all valid bits; data registers are
// not reset. No state is kept between words.
module curve25519_field_square (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [c25519fs_pkg::IN_W-1:0]       req_in_limb_0,
   input  logic [c25519fs_pkg::IN_W-1:0]       req_in_limb_1,
   input  logic [c25519fs_pkg::IN_W-1:0]       req_in_limb_2,
   input  logic [c25519fs_pkg::IN_W-1:0]       req_in_limb_3,
   input  logic [c25519fs_pkg::IN_W-1:0]       req_in_limb_4,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [c25519fs_pkg::LIMB_W-1:0]     rsp_out_limb_0,
   output logic [c25519fs_pkg::OUT1_W-1:0]     rsp_out_limb_1,
   output logic [c25519fs_pkg::LIMB_W-1:0]     rsp_out_limb_2,
   output logic [c25519fs_pkg::LIMB_W-1:0]     rsp_out_limb_3,
   output logic [c25519fs_pkg::LIMB_W-1:0]     rsp_out_limb_4
);

   localparam int unsigned NL    = c25519fs_pkg::NUM_LIMBS;
   localparam int unsigned TERMS = c25519fs_pkg::TERMS;
   localparam int unsigned NS    = c25519fs_pkg::TOTAL_STAGES;
   localparam int unsigned LS    = c25519fs_pkg::LANE_STAGES;
   localparam int unsigned IN_W  = c25519fs_pkg::IN_W;
   localparam int unsigned COL_W = c25519fs_pkg::COL_W;

   // Pipeline flow control: a stage loads when it is empty or the next one moves.
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] stage_en;

   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = stage_en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         valid_in[k] = stage_en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[NS-1];

   c25519fs_pkg::lane_ctl_type  lane_ctl;
   c25519fs_pkg::merge_ctl_type merge_ctl;

   assign lane_ctl.en  = stage_en[LS-1:0];
   assign merge_ctl.en = stage_en[NS-1:LS];

   // Route the limbs to each lane as its column's operand pairs.
   logic [IN_W-1:0]  limbs [NL];
   logic [COL_W-1:0] col   [NL];

   assign limbs[0] = req_in_limb_0;
   assign limbs[1] = req_in_limb_1;
   assign limbs[2] = req_in_limb_2;
   assign limbs[3] = req_in_limb_3;
   assign limbs[4] = req_in_limb_4;

   for (genvar c = 0; c < NL; c++) begin : g_lane
      logic [IN_W-1:0]         x     [TERMS];
      logic [IN_W-1:0]         y     [TERMS];
      c25519fs_pkg::scale_type scale [TERMS];

      for (genvar t = 0; t < TERMS; t++) begin : g_term
         assign x[t]     = limbs[c25519fs_pkg::X_SEL[c][t]];
         assign y[t]     = limbs[c25519fs_pkg::Y_SEL[c][t]];
         assign scale[t] = c25519fs_pkg::SCALE_SEL[c][t];
      end

      c25519fs_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .x     (x),
         .y     (y),
         .scale (scale),
         .col   (col[c])
      );
   end

   c25519fs_merge u_merge (
      .clock      (clock),
      .ctl        (merge_ctl),
      .col        (col),
      .out_limb_0 (rsp_out_limb_0),
      .out_limb_1 (rsp_out_limb_1),
      .out_limb_2 (rsp_out_limb_2),
      .out_limb_3 (rsp_out_limb_3),
      .out_limb_4 (rsp_out_limb_4)
   );

   // An accepted word always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted word did not enter the first stage");

   // With every stage full and the receiver stalled, no new word may be taken.
   assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_ready) |-> !req_ready)
      else $error("word accepted into a full, stalled pipeline");

   // Limb 1 exceeds 51 bits only by the small carry out of limb 0.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_limb_1[c25519fs_pkg::OUT1_W-1])
         |-> (rsp_out_limb_1[c25519fs_pkg::LIMB_W-1:c25519fs_pkg::TOP_CY_W] == '0))
      else $error("limb 1 carry larger than the fold allows");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
